// ===== rtl/gbi_pkg.sv =====
// Shared types, codes and helper functions for the gravity body integrator.
// No dependencies; the core, datapath, control and bench files refer to it by scoped names.
package gbi_pkg;

    // opcodes carried on the input tuser
    localparam logic [2:0] OP_ATTRACT     = 3'd0;
    localparam logic [2:0] OP_ATTRACT_INT = 3'd1;
    localparam logic [2:0] OP_INTEGRATE   = 3'd2;
    localparam logic [2:0] OP_ROT_LEFT    = 3'd3;
    localparam logic [2:0] OP_ROT_RIGHT   = 3'd4;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_GRAV_CONST = 3'd0;
    localparam logic [2:0] REG_PIXEL_SCALE = 3'd1;
    localparam logic [2:0] REG_OWN_MASS   = 3'd2;
    localparam logic [2:0] REG_TIME_STEP  = 3'd3;
    localparam logic [2:0] REG_ROT_FORCE  = 3'd4;
    localparam logic [2:0] REG_START_X    = 3'd5;
    localparam logic [2:0] REG_START_Y    = 3'd6;
    localparam logic [2:0] REG_START_ANG  = 3'd7;

    // time step is a Q0.16 fraction; damping factors in the same scale
    localparam int unsigned DT_BITS   = 16;
    localparam logic [31:0] DAMP_VEL  = 32'd64881;
    localparam logic [31:0] DAMP_SPIN = 32'd62259;

    // datapath micro-operations
    typedef enum logic [5:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_DX_GO,
        UOP_RX_SET,
        UOP_DY_GO,
        UOP_RY_SET,
        UOP_MUL_RXX,
        UOP_MUL_RYY,
        UOP_SQRT_GO,
        UOP_DIST_SET,
        UOP_MUL_MM,
        UOP_MUL_GM,
        UOP_DQ_GO,
        UOP_DF_GO,
        UOP_MUL_PX,
        UOP_DPX_GO,
        UOP_MUL_VX,
        UOP_VX_ADD,
        UOP_MUL_PY,
        UOP_DPY_GO,
        UOP_MUL_VY,
        UOP_VY_ADD,
        UOP_MUL_BX,
        UOP_BX_ADD,
        UOP_MUL_BY,
        UOP_BY_ADD,
        UOP_MUL_BA,
        UOP_BA_ADD,
        UOP_MUL_DVX,
        UOP_DVX_SET,
        UOP_MUL_DVY,
        UOP_DVY_SET,
        UOP_MUL_DSP,
        UOP_DSP_SET,
        UOP_MUL_ROT,
        UOP_ROT_SUB,
        UOP_ROT_ADD,
        UOP_OUT
    } t_uop;

    typedef struct packed {
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
    } t_sts;

    typedef struct packed {
        logic [31:0] grav_const;
        logic [31:0] pixel_scale;
        logic [31:0] own_mass;
        logic [15:0] time_step;
        logic [31:0] rot_force;
    } t_cfg;

    // magnitude of a signed word
    function automatic logic [31:0] f_abs(input logic signed [31:0] v);
        logic [31:0] res;
        res = v[31] ? (32'd0 - 32'(v)) : 32'(v);
        return res;
    endfunction

    // sign and magnitude to a saturated signed word
    function automatic logic signed [31:0] f_sat_sm(input logic neg, input logic [63:0] mag);
        logic signed [31:0] res;
        if (!neg) begin
            res = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(mag[31:0]);
        end else begin
            res = (mag > 64'h8000_0000) ? 32'sh8000_0000 : signed'(32'd0 - mag[31:0]);
        end
        return res;
    endfunction

    // v plus or minus a magnitude, saturated
    function automatic logic signed [31:0] f_sat_add(input logic signed [31:0] v,
                                                     input logic neg,
                                                     input logic [31:0] mag);
        logic signed [33:0] ext;
        logic signed [33:0] sum;
        logic signed [31:0] res;
        ext = 34'(v);
        sum = neg ? (ext - signed'({2'b00, mag})) : (ext + signed'({2'b00, mag}));
        if (sum > 34'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (sum < -34'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = sum[31:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/gravity_body_integrator_core.sv =====
// Gravity body integrator: one body under attractor pulls, Euler step with damping.
// An attractor word's run time is set by the shared one-bit-per-cycle divider (six divisions)
// and the bit-pair square root; integrate and rotate words use neither unit.
// One word is worked at a time; a result waits in the output register.
// Reset (synchronous, active low) loads the register defaults and zeroes all body state.
module gravity_body_integrator_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // attractor_x[31:0], attractor_y[63:32], attractor_mass[95:64]
    input  logic [2:0]   i_s_tuser,   // opcode[2:0]
    // output stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [95:0]  o_m_tdata,   // position_x[31:0], position_y[63:32], heading_angle[95:64]
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [31:0] r_grav, r_pscale, r_omass, r_rforce, r_sx, r_sy, r_sa;
    logic [15:0] r_tstep;
    logic        w_wr;
    logic [2:0]  w_idx;

    gbi_pkg::t_cmd w_cmd;
    gbi_pkg::t_sts w_sts;
    gbi_pkg::t_cfg w_cfg;
    logic signed [31:0] w_px, w_py, w_pa;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    // register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav   <= 32'd1 << FRAC_BITS;
            r_pscale <= 32'd1 << FRAC_BITS;
            r_omass  <= 32'd1 << FRAC_BITS;
            r_tstep  <= 16'd1092;
            r_rforce <= 32'd1 << FRAC_BITS;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sa     <= '0;
        end else if (w_wr) begin
            case (w_idx)
                gbi_pkg::REG_GRAV_CONST:  r_grav   <= pwdata;
                gbi_pkg::REG_PIXEL_SCALE: r_pscale <= pwdata;
                gbi_pkg::REG_OWN_MASS:    r_omass  <= pwdata;
                gbi_pkg::REG_TIME_STEP:   r_tstep  <= pwdata[15:0];
                gbi_pkg::REG_ROT_FORCE:   r_rforce <= pwdata;
                gbi_pkg::REG_START_X:     r_sx     <= pwdata;
                gbi_pkg::REG_START_Y:     r_sy     <= pwdata;
                gbi_pkg::REG_START_ANG:   r_sa     <= pwdata;
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            gbi_pkg::REG_GRAV_CONST:  prdata = r_grav;
            gbi_pkg::REG_PIXEL_SCALE: prdata = r_pscale;
            gbi_pkg::REG_OWN_MASS:    prdata = r_omass;
            gbi_pkg::REG_TIME_STEP:   prdata = 32'(r_tstep);
            gbi_pkg::REG_ROT_FORCE:   prdata = r_rforce;
            gbi_pkg::REG_START_X:     prdata = r_sx;
            gbi_pkg::REG_START_Y:     prdata = r_sy;
            gbi_pkg::REG_START_ANG:   prdata = r_sa;
            default:                  prdata = '0;
        endcase
    end

    assign w_cfg.grav_const  = r_grav;
    assign w_cfg.pixel_scale = r_pscale;
    assign w_cfg.own_mass    = r_omass;
    assign w_cfg.time_step   = r_tstep;
    assign w_cfg.rot_force   = r_rforce;

    gbi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    gbi_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_cfg   (w_cfg),
        .i_ax    (signed'(i_s_tdata[31:0])),
        .i_ay    (signed'(i_s_tdata[63:32])),
        .i_am    (i_s_tdata[95:64]),
        .o_pos_x (w_px),
        .o_pos_y (w_py),
        .o_angle (w_pa)
    );

    assign o_m_tdata = {w_pa, w_py, w_px};

    // iterative units only run while no new word can be taken
    a_div_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.div_busy |-> !o_s_tready) else $error("divider busy while accepting");
    a_sqrt_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.sqrt_busy |-> !o_s_tready) else $error("square root busy while accepting");
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_sts.div_busy && w_sts.sqrt_busy)) else $error("divider and square root overlap");

endmodule

// ===== rtl/gbi_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Depends on nothing; used by gbi_datapath.
module gbi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    input  logic [6:0]  i_steps,
    output logic        o_busy,
    output logic [63:0] o_quot
);

    logic [63:0] r_num;
    logic [31:0] r_den;
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [6:0]  r_cnt;
    logic [32:0] w_rem_sh;
    logic        w_ge;

    // shift in next dividend bit and trial-subtract
    assign w_rem_sh = {r_rem, r_num[63]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 7'd1;
        end
    end

    // payload: dividend left-aligned so only the used bits are walked
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num << (7'd64 - i_steps);
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[62:0], 1'b0};
            r_rem <= w_ge ? 32'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[31:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quo;

endmodule

// ===== rtl/gbi_sqrt.sv =====
// Bit-pair integer square root of a 64-bit value.
// Depends on nothing; used by gbi_datapath.
module gbi_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_busy,
    output logic [31:0] o_root
);

    logic [63:0] r_n;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] w_try;

    assign w_try = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_bit != '0) begin
            r_bit <= r_bit >> 2;
        end
    end

    // one result bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_val;
            r_res <= '0;
        end else if (r_bit != '0) begin
            if (r_n >= w_try) begin
                r_n   <= r_n - w_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_busy = (r_bit != '0);
    assign o_root = r_res[31:0];

endmodule

// ===== rtl/gbi_datapath.sv =====
// Body state, shared multiplier, divider and square root unit of the integrator.
// Depends on gbi_pkg, gbi_div and gbi_sqrt; driven by gbi_ctrl micro-operations.
module gbi_datapath #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gbi_pkg::t_cmd       i_cmd,
    output gbi_pkg::t_sts       o_sts,
    input  gbi_pkg::t_cfg       i_cfg,
    input  logic signed [31:0]  i_ax,
    input  logic signed [31:0]  i_ay,
    input  logic [31:0]         i_am,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_angle
);

    localparam logic [31:0] ONE       = 32'd1 << FRAC_BITS;
    localparam logic [6:0]  STEPS_OFS = 7'(33 + FRAC_BITS);
    localparam logic [6:0]  STEPS_Q   = 7'(32 + FRAC_BITS);
    localparam logic [6:0]  STEPS_ALL = 7'd64;

    // body state
    logic signed [31:0] r_bx, r_by, r_ang, r_vx, r_vy, r_sp;
    // per-item working registers
    logic signed [31:0] r_ax, r_ay, r_rx, r_ry;
    logic [31:0]        r_am, r_dist, r_force;
    logic               r_neg_x, r_neg_y;
    logic [63:0]        r_prod, r_acc;
    logic signed [31:0] r_out_x, r_out_y, r_out_a;

    logic [31:0]        w_ma, w_mb;
    logic               w_mul_en;
    logic               w_div_go;
    logic [63:0]        w_div_num;
    logic [31:0]        w_div_den;
    logic [6:0]         w_div_steps;
    logic               w_div_busy;
    logic [63:0]        w_quot;
    logic               w_sqrt_busy;
    logic [31:0]        w_root;
    logic signed [32:0] w_dx, w_dy;
    logic [32:0]        w_mag_x, w_mag_y;
    logic [31:0]        w_ps;
    logic [63:0]        w_prod_shf;
    logic [31:0]        w_prod_sat;
    logic [31:0]        w_prod_dt;

    // offsets and clamped scale
    assign w_dx    = 33'(r_ax) - 33'(r_bx);
    assign w_dy    = 33'(r_ay) - 33'(r_by);
    assign w_mag_x = w_dx[32] ? (33'd0 - 33'(w_dx)) : 33'(w_dx);
    assign w_mag_y = w_dy[32] ? (33'd0 - 33'(w_dy)) : 33'(w_dy);
    assign w_ps    = (i_cfg.pixel_scale < ONE) ? ONE : i_cfg.pixel_scale;

    // product after the fraction shift, saturated unsigned; and the Q0.16 scaling
    assign w_prod_shf = r_prod >> FRAC_BITS;
    assign w_prod_sat = (w_prod_shf[63:32] != '0) ? 32'hFFFF_FFFF : w_prod_shf[31:0];
    assign w_prod_dt  = r_prod[gbi_pkg::DT_BITS +: 32];

    // multiplier operand select
    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_mul_en = 1'b1;
        case (i_cmd.uop)
            gbi_pkg::UOP_MUL_RXX: begin w_ma = gbi_pkg::f_abs(r_rx); w_mb = w_ma; end
            gbi_pkg::UOP_MUL_RYY: begin w_ma = gbi_pkg::f_abs(r_ry); w_mb = w_ma; end
            gbi_pkg::UOP_MUL_MM:  begin w_ma = r_am; w_mb = i_cfg.own_mass; end
            gbi_pkg::UOP_MUL_GM:  begin w_ma = i_cfg.grav_const; w_mb = w_prod_sat; end
            gbi_pkg::UOP_MUL_PX:  begin w_ma = w_quot[31:0]; w_mb = gbi_pkg::f_abs(r_rx); end
            gbi_pkg::UOP_MUL_PY:  begin w_ma = r_force; w_mb = gbi_pkg::f_abs(r_ry); end
            gbi_pkg::UOP_MUL_VX,
            gbi_pkg::UOP_MUL_VY:  begin w_ma = w_quot[31:0]; w_mb = 32'(i_cfg.time_step); end
            gbi_pkg::UOP_MUL_BX:  begin w_ma = gbi_pkg::f_abs(r_vx); w_mb = 32'(i_cfg.time_step); end
            gbi_pkg::UOP_MUL_BY:  begin w_ma = gbi_pkg::f_abs(r_vy); w_mb = 32'(i_cfg.time_step); end
            gbi_pkg::UOP_MUL_BA:  begin w_ma = gbi_pkg::f_abs(r_sp); w_mb = 32'(i_cfg.time_step); end
            gbi_pkg::UOP_MUL_DVX: begin w_ma = gbi_pkg::f_abs(r_vx); w_mb = gbi_pkg::DAMP_VEL; end
            gbi_pkg::UOP_MUL_DVY: begin w_ma = gbi_pkg::f_abs(r_vy); w_mb = gbi_pkg::DAMP_VEL; end
            gbi_pkg::UOP_MUL_DSP: begin w_ma = gbi_pkg::f_abs(r_sp); w_mb = gbi_pkg::DAMP_SPIN; end
            gbi_pkg::UOP_MUL_ROT: begin w_ma = i_cfg.rot_force; w_mb = 32'(i_cfg.time_step); end
            default:              w_mul_en = 1'b0;
        endcase
    end

    // divider command select
    always_comb begin
        w_div_go    = 1'b1;
        w_div_num   = '0;
        w_div_den   = r_dist;
        w_div_steps = STEPS_ALL;
        case (i_cmd.uop)
            gbi_pkg::UOP_DX_GO: begin
                w_div_num = 64'(w_mag_x) << FRAC_BITS;
                w_div_den = w_ps;
                w_div_steps = STEPS_OFS;
            end
            gbi_pkg::UOP_DY_GO: begin
                w_div_num = 64'(w_mag_y) << FRAC_BITS;
                w_div_den = w_ps;
                w_div_steps = STEPS_OFS;
            end
            gbi_pkg::UOP_DQ_GO: begin
                w_div_num = 64'(w_prod_sat) << FRAC_BITS;
                w_div_steps = STEPS_Q;
            end
            gbi_pkg::UOP_DF_GO: begin
                w_div_num = 64'(w_quot[31:0]) << FRAC_BITS;
                w_div_steps = STEPS_Q;
            end
            gbi_pkg::UOP_DPX_GO,
            gbi_pkg::UOP_DPY_GO: w_div_num = r_prod;
            default:             w_div_go = 1'b0;
        endcase
    end

    gbi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_steps (w_div_steps),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    gbi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.uop == gbi_pkg::UOP_SQRT_GO),
        .i_val   (r_acc + r_prod),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_root)
    );

    // body state; reset zeroes it, and the start registers are never loaded into it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bx  <= '0;
            r_by  <= '0;
            r_ang <= '0;
            r_vx  <= '0;
            r_vy  <= '0;
            r_sp  <= '0;
        end else begin
            case (i_cmd.uop)
                gbi_pkg::UOP_VX_ADD:  r_vx  <= gbi_pkg::f_sat_add(r_vx, r_neg_x, w_prod_dt);
                gbi_pkg::UOP_VY_ADD:  r_vy  <= gbi_pkg::f_sat_add(r_vy, r_neg_y, w_prod_dt);
                gbi_pkg::UOP_BX_ADD:  r_bx  <= gbi_pkg::f_sat_add(r_bx, r_vx[31], w_prod_dt);
                gbi_pkg::UOP_BY_ADD:  r_by  <= gbi_pkg::f_sat_add(r_by, r_vy[31], w_prod_dt);
                gbi_pkg::UOP_BA_ADD:  r_ang <= gbi_pkg::f_sat_add(r_ang, r_sp[31], w_prod_dt);
                gbi_pkg::UOP_DVX_SET: r_vx  <= gbi_pkg::f_sat_sm(r_vx[31], 64'(w_prod_dt));
                gbi_pkg::UOP_DVY_SET: r_vy  <= gbi_pkg::f_sat_sm(r_vy[31], 64'(w_prod_dt));
                gbi_pkg::UOP_DSP_SET: r_sp  <= gbi_pkg::f_sat_sm(r_sp[31], 64'(w_prod_dt));
                gbi_pkg::UOP_ROT_SUB: r_sp  <= gbi_pkg::f_sat_add(r_sp, 1'b1, w_prod_dt);
                gbi_pkg::UOP_ROT_ADD: r_sp  <= gbi_pkg::f_sat_add(r_sp, 1'b0, w_prod_dt);
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= 64'(w_ma) * 64'(w_mb);
        end
        case (i_cmd.uop)
            gbi_pkg::UOP_LOAD: begin
                r_ax <= i_ax;
                r_ay <= i_ay;
                r_am <= i_am;
            end
            gbi_pkg::UOP_DX_GO:    r_neg_x <= w_dx[32];
            gbi_pkg::UOP_DY_GO:    r_neg_y <= w_dy[32];
            gbi_pkg::UOP_RX_SET:   r_rx <= gbi_pkg::f_sat_sm(r_neg_x, w_quot);
            gbi_pkg::UOP_RY_SET:   r_ry <= gbi_pkg::f_sat_sm(r_neg_y, w_quot);
            gbi_pkg::UOP_MUL_RYY:  r_acc <= r_prod;
            gbi_pkg::UOP_DIST_SET: r_dist <= (w_root < ONE) ? ONE : w_root;
            gbi_pkg::UOP_MUL_PX: begin
                // pull sign follows the clamped offset
                r_force <= w_quot[31:0];
                r_neg_x <= r_rx[31];
                r_neg_y <= r_ry[31];
            end
            gbi_pkg::UOP_OUT: begin
                r_out_x <= r_bx;
                r_out_y <= r_by;
                r_out_a <= r_ang;
            end
            default: ;
        endcase
    end

    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.sqrt_busy = w_sqrt_busy;
    assign o_pos_x = r_out_x;
    assign o_pos_y = r_out_y;
    assign o_angle = r_out_a;

endmodule

// ===== rtl/gbi_ctrl.sv =====
// Sequencer of the integrator: input handshake, micro-operation order, output valid.
// Depends on gbi_pkg; drives gbi_datapath through t_cmd and watches t_sts.
module gbi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic [2:0]    i_s_tuser,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output gbi_pkg::t_cmd o_cmd,
    input  gbi_pkg::t_sts i_sts
);

    typedef enum logic [5:0] {
        S_IDLE, S_DX, S_DXW, S_DY, S_DYW, S_SQX, S_SQY, S_RT, S_RTW,
        S_MM, S_GM, S_DQ, S_DQW, S_DF, S_DFW, S_PXM, S_PXD, S_PXW, S_VXM, S_VXA,
        S_PYM, S_PYD, S_PYW, S_VYM, S_VYA,
        S_IBX, S_IBXA, S_IBY, S_IBYA, S_IBA, S_IBAA,
        S_DVX, S_DVXA, S_DVY, S_DVYA, S_DSP, S_DSPA,
        S_ROT, S_ROTA, S_OUT
    } t_state;

    t_state       r_state, n_state;
    logic [2:0]   r_op;
    logic         r_out_valid;
    gbi_pkg::t_uop w_uop;
    logic         w_out_load;

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    // next state and micro-operation
    always_comb begin
        n_state = r_state;
        w_uop   = gbi_pkg::UOP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    w_uop = gbi_pkg::UOP_LOAD;
                    case (i_s_tuser)
                        gbi_pkg::OP_ATTRACT,
                        gbi_pkg::OP_ATTRACT_INT: n_state = S_DX;
                        gbi_pkg::OP_INTEGRATE:   n_state = S_IBX;
                        gbi_pkg::OP_ROT_LEFT,
                        gbi_pkg::OP_ROT_RIGHT:   n_state = S_ROT;
                        default:                 n_state = S_IDLE;
                    endcase
                end
            end
            // scaled offsets
            S_DX:  begin w_uop = gbi_pkg::UOP_DX_GO; n_state = S_DXW; end
            S_DXW: if (!i_sts.div_busy) begin w_uop = gbi_pkg::UOP_RX_SET; n_state = S_DY; end
            S_DY:  begin w_uop = gbi_pkg::UOP_DY_GO; n_state = S_DYW; end
            S_DYW: if (!i_sts.div_busy) begin w_uop = gbi_pkg::UOP_RY_SET; n_state = S_SQX; end
            // distance
            S_SQX: begin w_uop = gbi_pkg::UOP_MUL_RXX; n_state = S_SQY; end
            S_SQY: begin w_uop = gbi_pkg::UOP_MUL_RYY; n_state = S_RT; end
            S_RT:  begin w_uop = gbi_pkg::UOP_SQRT_GO; n_state = S_RTW; end
            S_RTW: if (!i_sts.sqrt_busy) begin w_uop = gbi_pkg::UOP_DIST_SET; n_state = S_MM; end
            // force magnitude
            S_MM:  begin w_uop = gbi_pkg::UOP_MUL_MM; n_state = S_GM; end
            S_GM:  begin w_uop = gbi_pkg::UOP_MUL_GM; n_state = S_DQ; end
            S_DQ:  begin w_uop = gbi_pkg::UOP_DQ_GO; n_state = S_DQW; end
            S_DQW: if (!i_sts.div_busy) n_state = S_DF;
            S_DF:  begin w_uop = gbi_pkg::UOP_DF_GO; n_state = S_DFW; end
            S_DFW: if (!i_sts.div_busy) n_state = S_PXM;
            // pull along x and y into velocity
            S_PXM: begin w_uop = gbi_pkg::UOP_MUL_PX; n_state = S_PXD; end
            S_PXD: begin w_uop = gbi_pkg::UOP_DPX_GO; n_state = S_PXW; end
            S_PXW: if (!i_sts.div_busy) n_state = S_VXM;
            S_VXM: begin w_uop = gbi_pkg::UOP_MUL_VX; n_state = S_VXA; end
            S_VXA: begin w_uop = gbi_pkg::UOP_VX_ADD; n_state = S_PYM; end
            S_PYM: begin w_uop = gbi_pkg::UOP_MUL_PY; n_state = S_PYD; end
            S_PYD: begin w_uop = gbi_pkg::UOP_DPY_GO; n_state = S_PYW; end
            S_PYW: if (!i_sts.div_busy) n_state = S_VYM;
            S_VYM: begin w_uop = gbi_pkg::UOP_MUL_VY; n_state = S_VYA; end
            S_VYA: begin
                w_uop   = gbi_pkg::UOP_VY_ADD;
                n_state = (r_op == gbi_pkg::OP_ATTRACT_INT) ? S_IBX : S_IDLE;
            end
            // integration and damping
            S_IBX:  begin w_uop = gbi_pkg::UOP_MUL_BX;  n_state = S_IBXA; end
            S_IBXA: begin w_uop = gbi_pkg::UOP_BX_ADD;  n_state = S_IBY; end
            S_IBY:  begin w_uop = gbi_pkg::UOP_MUL_BY;  n_state = S_IBYA; end
            S_IBYA: begin w_uop = gbi_pkg::UOP_BY_ADD;  n_state = S_IBA; end
            S_IBA:  begin w_uop = gbi_pkg::UOP_MUL_BA;  n_state = S_IBAA; end
            S_IBAA: begin w_uop = gbi_pkg::UOP_BA_ADD;  n_state = S_DVX; end
            S_DVX:  begin w_uop = gbi_pkg::UOP_MUL_DVX; n_state = S_DVXA; end
            S_DVXA: begin w_uop = gbi_pkg::UOP_DVX_SET; n_state = S_DVY; end
            S_DVY:  begin w_uop = gbi_pkg::UOP_MUL_DVY; n_state = S_DVYA; end
            S_DVYA: begin w_uop = gbi_pkg::UOP_DVY_SET; n_state = S_DSP; end
            S_DSP:  begin w_uop = gbi_pkg::UOP_MUL_DSP; n_state = S_DSPA; end
            S_DSPA: begin w_uop = gbi_pkg::UOP_DSP_SET; n_state = S_OUT; end
            // rotation
            S_ROT:  begin w_uop = gbi_pkg::UOP_MUL_ROT; n_state = S_ROTA; end
            S_ROTA: begin
                w_uop   = (r_op == gbi_pkg::OP_ROT_LEFT) ? gbi_pkg::UOP_ROT_SUB
                                                        : gbi_pkg::UOP_ROT_ADD;
                n_state = S_IDLE;
            end
            // result word waits for a free output register
            S_OUT: if (w_out_load) begin w_uop = gbi_pkg::UOP_OUT; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= gbi_pkg::OP_ATTRACT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_s_tvalid) begin
                r_op <= i_s_tuser;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd.uop  = w_uop;

endmodule

// ===== bench/gbi_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the gravity body integrator: tracks config writes, predicts each result word.
// Depends on gbi_pkg for opcodes, register indexes and scaling constants; instantiated by testbench.
module gbi_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [95:0] i_s_tdata,
    input  logic [2:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending
);

    localparam int FRAC = 16;
    localparam longint ONE = longint'(1) << FRAC;

    // register copies
    logic [31:0] grav_const, pixel_scale, own_mass, rot_force;
    logic [15:0] time_step;

    // body state
    longint pos_x, pos_y, heading, vel_x, vel_y, spin;

    logic [95:0] expected_words[$];

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint sat_u32(input longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : longint'(v);
    endfunction

    // trunc(v * k / 2^16), rounding toward zero
    function automatic longint frac_scale(input longint v, input longint unsigned k);
        longint unsigned mag;
        longint unsigned prod;
        mag = (v < 0) ? longint'(-v) : v;
        prod = (mag * k) >> gbi_pkg::DT_BITS;
        return (v < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // gravitational pull of one attractor, added to the velocity
    task automatic apply_pull(input longint ax, input longint ay, input longint unsigned am);
        longint ps, rx, ry, px, py;
        longint unsigned d2, dist_u, mm, gm, q, force_u;
        ps = (pixel_scale < ONE) ? ONE : longint'(pixel_scale);
        rx = sat32(((ax - pos_x) * ONE) / ps);
        ry = sat32(((ay - pos_y) * ONE) / ps);
        d2 = longint'(rx * rx) + longint'(ry * ry);
        dist_u = int_sqrt(d2);
        if (dist_u < ONE) dist_u = ONE;
        mm = sat_u32((am * longint'(own_mass)) >> FRAC);
        gm = sat_u32((longint'(grav_const) * mm) >> FRAC);
        q = (gm << FRAC) / dist_u;
        force_u = (q << FRAC) / dist_u;
        px = (longint'(force_u) * rx) / longint'(dist_u);
        py = (longint'(force_u) * ry) / longint'(dist_u);
        vel_x = sat32(vel_x + frac_scale(px, time_step));
        vel_y = sat32(vel_y + frac_scale(py, time_step));
    endtask

    // Euler step, then damping
    task automatic integrate_step();
        pos_x = sat32(pos_x + frac_scale(vel_x, time_step));
        pos_y = sat32(pos_y + frac_scale(vel_y, time_step));
        heading = sat32(heading + frac_scale(spin, time_step));
        vel_x = frac_scale(vel_x, gbi_pkg::DAMP_VEL);
        vel_y = frac_scale(vel_y, gbi_pkg::DAMP_VEL);
        spin = frac_scale(spin, gbi_pkg::DAMP_SPIN);
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch %s", $realtime, msg);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        logic [95:0] want;
        longint ax, ay;
        if (!i_rst_n) begin
            grav_const  <= 32'd65536;
            pixel_scale <= 32'd65536;
            own_mass    <= 32'd65536;
            time_step   <= 16'd1092;
            rot_force   <= 32'd65536;
            pos_x = 0; pos_y = 0; heading = 0;
            vel_x = 0; vel_y = 0; spin = 0;
        end else begin
            // result word against oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word %h", i_m_tdata));
                end else begin
                    want = expected_words.pop_front();
                    if (i_m_tdata[31:0] !== want[31:0])
                        report_mismatch($sformatf("position_x: got %h, expected %h",
                                                  i_m_tdata[31:0], want[31:0]));
                    if (i_m_tdata[63:32] !== want[63:32])
                        report_mismatch($sformatf("position_y: got %h, expected %h",
                                                  i_m_tdata[63:32], want[63:32]));
                    if (i_m_tdata[95:64] !== want[95:64])
                        report_mismatch($sformatf("heading_angle: got %h, expected %h",
                                                  i_m_tdata[95:64], want[95:64]));
                end
            end
            // input word
            if (i_s_tvalid && i_s_tready) begin
                ax = longint'($signed(i_s_tdata[31:0]));
                ay = longint'($signed(i_s_tdata[63:32]));
                case (i_s_tuser)
                    gbi_pkg::OP_ATTRACT: apply_pull(ax, ay, i_s_tdata[95:64]);
                    gbi_pkg::OP_ATTRACT_INT: begin
                        apply_pull(ax, ay, i_s_tdata[95:64]);
                        integrate_step();
                    end
                    gbi_pkg::OP_INTEGRATE: integrate_step();
                    gbi_pkg::OP_ROT_LEFT:
                        spin = sat32(spin - frac_scale(rot_force, time_step));
                    gbi_pkg::OP_ROT_RIGHT:
                        spin = sat32(spin + frac_scale(rot_force, time_step));
                    default: ;
                endcase
                if (i_s_tuser == gbi_pkg::OP_ATTRACT_INT || i_s_tuser == gbi_pkg::OP_INTEGRATE)
                    expected_words.push_back({heading[31:0], pos_y[31:0], pos_x[31:0]});
            end
            // register writes; start registers are not tracked, as the block never uses them
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    gbi_pkg::REG_GRAV_CONST:  grav_const  <= i_pwdata;
                    gbi_pkg::REG_PIXEL_SCALE: pixel_scale <= i_pwdata;
                    gbi_pkg::REG_OWN_MASS:    own_mass    <= i_pwdata;
                    gbi_pkg::REG_TIME_STEP:   time_step   <= i_pwdata[15:0];
                    gbi_pkg::REG_ROT_FORCE:   rot_force   <= i_pwdata;
                    default: ;
                endcase
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Top of the gravity body integrator bench: clock, reset, stimulus and verdict.
// Depends on gbi_pkg, gravity_body_integrator_core and gbi_checker.
module testbench;

    // opcodes the block ignores
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
    localparam int STALL_LIMIT = 30000;
    localparam int DRAIN_CYCLES = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [95:0] i_s_tdata = '0;   // attractor_x, attractor_y, attractor_mass
    logic [2:0]  i_s_tuser = '0;   // opcode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [95:0] o_m_tdata;        // position_x, position_y, heading_angle
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors, pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    gravity_body_integrator_core u_dut (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .o_s_tready, .i_s_tdata, .i_s_tuser,
        .o_m_tvalid, .i_m_tready, .o_m_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    gbi_checker u_checker (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver back-pressure
    always @(negedge i_clk) i_m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send_word(input logic [2:0] op, input logic [31:0] ax,
                             input logic [31:0] ay, input logic [31:0] am);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tuser = op;
        i_s_tdata = {am, ay, ax};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // let every result drain, then cover the no-result tail of an attractor word
    task automatic settle();
        i_s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
            default: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        return ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 32'h0010_0000);
    endfunction

    task automatic random_words(input int count);
        int r;
        logic [2:0] op;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 50)      op = gbi_pkg::OP_ATTRACT;
            else if (r < 65) op = gbi_pkg::OP_ATTRACT_INT;
            else if (r < 80) op = gbi_pkg::OP_INTEGRATE;
            else if (r < 88) op = gbi_pkg::OP_ROT_LEFT;
            else if (r < 96) op = gbi_pkg::OP_ROT_RIGHT;
            else             op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            send_word(op, rand_coord(), rand_coord(), rand_mass());
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // start registers are written but never loaded into the body state
        write_reg(gbi_pkg::REG_START_X, 32'h7FFF_FFFF);
        write_reg(gbi_pkg::REG_START_Y, 32'h8000_0000);
        write_reg(gbi_pkg::REG_START_ANG, $urandom());

        // directed: extremes, every opcode, close and far attractors
        send_word(gbi_pkg::OP_ATTRACT, 32'h0, 32'h0, 32'h0001_0000);           // zero offset
        send_word(gbi_pkg::OP_ATTRACT, 32'h0000_8000, 32'h0, 32'hFFFF_FFFF);   // inside one unit
        send_word(gbi_pkg::OP_ATTRACT_INT, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(gbi_pkg::OP_ATTRACT_INT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_word(gbi_pkg::OP_INTEGRATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(gbi_pkg::OP_ROT_LEFT, 32'h0, 32'h0, 32'h0);
        send_word(gbi_pkg::OP_ROT_RIGHT, 32'h0, 32'h0, 32'h0);
        send_word(gbi_pkg::OP_ROT_RIGHT, 32'h0, 32'h0, 32'h0);
        send_word(gbi_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0);
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
            send_word(3'(op), $urandom(), $urandom(), $urandom());
        send_word(gbi_pkg::OP_ATTRACT, 32'h0010_0000, 32'hFFF0_0000, 32'h0100_0000);
        send_word(gbi_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0);
        settle();

        // saturating settings: largest constants, longest step, pixel scale below one
        write_reg(gbi_pkg::REG_GRAV_CONST, 32'hFFFF_FFFF);
        write_reg(gbi_pkg::REG_OWN_MASS, 32'hFFFF_FFFF);
        write_reg(gbi_pkg::REG_TIME_STEP, 32'h0000_FFFF);
        write_reg(gbi_pkg::REG_ROT_FORCE, 32'hFFFF_FFFF);
        write_reg(gbi_pkg::REG_PIXEL_SCALE, 32'h0);
        for (int i = 0; i < 4; i++) send_word(gbi_pkg::OP_ROT_RIGHT, 32'h0, 32'h0, 32'h0);
        send_word(gbi_pkg::OP_ATTRACT_INT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(gbi_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0);
        for (int i = 0; i < 8; i++) send_word(gbi_pkg::OP_ROT_LEFT, 32'h0, 32'h0, 32'h0);
        send_word(gbi_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0);
        settle();

        // phase 1: no idling, moderate settings
        write_reg(gbi_pkg::REG_GRAV_CONST, 32'h0004_0000);
        write_reg(gbi_pkg::REG_OWN_MASS, 32'h0002_0000);
        write_reg(gbi_pkg::REG_PIXEL_SCALE, 32'h0001_0000);
        write_reg(gbi_pkg::REG_TIME_STEP, 32'd1092);
        write_reg(gbi_pkg::REG_ROT_FORCE, 32'h0010_0000);
        random_words(200);
        settle();

        // phase 2: sender idles, zero time step and zero gravity
        send_idle_pct = 50;
        write_reg(gbi_pkg::REG_TIME_STEP, 32'h0);
        write_reg(gbi_pkg::REG_GRAV_CONST, 32'h0);
        write_reg(gbi_pkg::REG_PIXEL_SCALE, 32'hFFFF_FFFF);
        random_words(200);
        settle();

        // phase 3: receiver stalls, random settings
        send_idle_pct = 0;
        recv_stall_pct = 50;
        write_reg(gbi_pkg::REG_GRAV_CONST, $urandom());
        write_reg(gbi_pkg::REG_OWN_MASS, $urandom());
        write_reg(gbi_pkg::REG_PIXEL_SCALE, $urandom_range(32'h0001_0000, 32'h0010_0000));
        write_reg(gbi_pkg::REG_TIME_STEP, $urandom());
        write_reg(gbi_pkg::REG_ROT_FORCE, $urandom());
        random_words(200);
        settle();

        // phase 4: both sides idle
        send_idle_pct = 27;
        recv_stall_pct = 27;
        write_reg(gbi_pkg::REG_TIME_STEP, 32'h0000_FFFF);
        write_reg(gbi_pkg::REG_GRAV_CONST, 32'h0100_0000);
        random_words(200);
        settle();

        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

// ===== gravity_body_integrator_core.f =====
rtl/gbi_pkg.sv
rtl/gbi_div.sv
rtl/gbi_sqrt.sv
rtl/gbi_datapath.sv
rtl/gbi_ctrl.sv
rtl/gravity_body_integrator_core.sv
bench/gbi_checker.sv
bench/testbench.sv
